@@ hdl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module of the unit.
package rau_pkg;

    // Result range: numerator in [-2^(W-1), 2^(W-1)-1], denominator in [1, 2^(W-1)-1]
    localparam int WIDTH = 32;
    localparam int EFF_W = (WIDTH > 32) ? 32 : ((WIDTH < 2) ? 2 : WIDTH);
    localparam logic [63:0] MAXPOS  = (64'd1 << (EFF_W - 1)) - 64'd1;
    localparam logic [63:0] POW_CAP = 64'd1 << (EFF_W - 1);

    // Input and output beat layout
    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command codes
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Operation class decided by the front
    typedef enum logic [2:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV,
        OP_POW,
        OP_ERR
    } op_t;

    // Classified item; subtract arrives as add with b's sign flipped
    typedef struct packed {
        op_t         op;
        logic [1:0]  status;
        logic        a_neg;
        logic        b_neg;
        logic        e_neg;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        logic [31:0] e_mag;
    } item_t;

endpackage

@@ hdl/rau_front.sv @@
// Front of the rational arithmetic unit: takes input beats, checks operands
// and classifies the command. Depends on rau_pkg.
module rau_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rau_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output rau_pkg::item_t                 q_item
);
    import rau_pkg::*;

    logic [2:0]  cmd;
    logic [31:0] a_num, a_den, b_num, b_den, expo;
    logic        ad_bad, bd_bad;

    assign cmd   = s_tuser;
    assign a_num = s_tdata[31:0];
    assign a_den = s_tdata[63:32];
    assign b_num = s_tdata[95:64];
    assign b_den = s_tdata[127:96];
    assign expo  = s_tdata[159:128];

    // handshake
    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    assign ad_bad = a_den[31] | (a_den == 32'd0);
    assign bd_bad = b_den[31] | (b_den == 32'd0);

    // magnitudes, signs and operation class
    always_comb
    begin
        q_item.an    = a_num[31] ? (~a_num + 32'd1) : a_num;
        q_item.bn    = b_num[31] ? (~b_num + 32'd1) : b_num;
        q_item.ad    = a_den;
        q_item.bd    = b_den;
        q_item.e_mag = expo[31] ? (~expo + 32'd1) : expo;
        q_item.e_neg = expo[31];
        q_item.a_neg = a_num[31];
        q_item.b_neg = (cmd == CMD_SUB) ? ~b_num[31] : b_num[31];
        q_item.status = ST_OK;
        q_item.op     = OP_ERR;
        priority if (cmd > CMD_POW || ad_bad || (cmd != CMD_POW && bd_bad))
        begin
            q_item.status = ST_INVALID;
        end
        else if (cmd == CMD_DIV && b_num == 32'd0)
        begin
            q_item.status = ST_DIVZERO;
        end
        else
        begin
            unique case (cmd)
                CMD_ADD, CMD_SUB: q_item.op = OP_ADD;
                CMD_MUL:          q_item.op = OP_MUL;
                CMD_DIV:          q_item.op = OP_DIV;
                CMD_POW:          q_item.op = OP_POW;
                default:
                begin
                    q_item.op     = OP_ERR;
                    q_item.status = ST_INVALID;
                end
            endcase
        end
    end

endmodule

@@ hdl/rau_fifo.sv @@
// Short queue of classified items between front and back.
// Depends on rau_pkg.
module rau_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rau_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output rau_pkg::item_t pop_item
);
    import rau_pkg::*;

    item_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem[rd_ptr_reg];
    assign do_push  = push & ~full;
    assign do_pop   = pop & valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/rau_back.sv @@
// Back of the rational arithmetic unit: sequencer with one shared 32x32
// multiplier, a binary gcd, a two-quotient restoring divider and the output
// register. Depends on rau_pkg.
module rau_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rau_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    res_num,
    output logic [30:0]    res_den,
    output logic [1:0]     status
);
    import rau_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MUL   = 12'b000000000010,
        S_SUM   = 12'b000000000100,
        S_GCD   = 12'b000000001000,
        S_DIV   = 12'b000000010000,
        S_PSET  = 12'b000000100000,
        S_PINIT = 12'b000001000000,
        S_PMUL  = 12'b000010000000,
        S_PCHK  = 12'b000100000000,
        S_PNEXT = 12'b001000000000,
        S_CHK   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    item_t       it_reg;
    logic [6:0]  step_reg;
    logic [63:0] prod_reg, t1_reg, t2_reg, num_reg, den_reg;
    logic [63:0] x_reg, y_reg, g_reg, rem_n_reg, rem_d_reg;
    logic [5:0]  k_reg;
    logic        neg_reg, pow_pass_reg, which_reg;
    logic [31:0] base_reg, r_reg, pp_reg, cnt_reg;
    logic [31:0] res_num_reg;
    logic [30:0] res_den_reg;
    logic [1:0]  status_reg;

    logic [31:0] op_a, op_b;
    logic        gcd_done;
    logic [63:0] g_val;
    logic [64:0] rn_sh, rd_sh, rn_dif, rd_dif;
    logic [63:0] sum_m;
    logic        sum_neg;
    logic        mag0, neg_e, ovf;
    logic [63:0] den_e;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = (state_reg == S_OUT);
    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign status   = status_reg;

    // shared multiplier operands
    always_comb
    begin
        op_a = 32'd0;
        op_b = 32'd0;
        unique case (state_reg)
            S_MUL:
            begin
                unique case (step_reg[1:0])
                    2'd0:
                    begin
                        op_a = it_reg.an;
                        op_b = (it_reg.op == OP_MUL) ? it_reg.bn : it_reg.bd;
                    end
                    2'd1:
                    begin
                        op_a = it_reg.bn;
                        op_b = it_reg.ad;
                    end
                    2'd2:
                    begin
                        op_a = it_reg.ad;
                        op_b = (it_reg.op == OP_DIV) ? it_reg.bn : it_reg.bd;
                    end
                    default:
                    begin
                        op_a = 32'd0;
                        op_b = 32'd0;
                    end
                endcase
            end
            S_PMUL:
            begin
                op_a = r_reg;
                op_b = base_reg;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    // gcd finish and divider step
    assign gcd_done = (x_reg == 64'd0) || (y_reg == 64'd0);
    assign g_val    = (x_reg | y_reg) << k_reg;
    assign rn_sh    = {rem_n_reg, num_reg[63]};
    assign rd_sh    = {rem_d_reg, den_reg[63]};
    assign rn_dif   = rn_sh - {1'b0, g_reg};
    assign rd_dif   = rd_sh - {1'b0, g_reg};

    // signed sum of the two cross products
    always_comb
    begin
        priority if (it_reg.a_neg == it_reg.b_neg)
        begin
            sum_m   = t1_reg + t2_reg;
            sum_neg = it_reg.a_neg;
        end
        else if (t1_reg >= t2_reg)
        begin
            sum_m   = t1_reg - t2_reg;
            sum_neg = it_reg.a_neg;
        end
        else
        begin
            sum_m   = t2_reg - t1_reg;
            sum_neg = it_reg.b_neg;
        end
    end

    // range check of the reduced result
    assign mag0  = (num_reg == 64'd0);
    assign den_e = mag0 ? 64'd1 : den_reg;
    assign neg_e = neg_reg & ~mag0;
    assign ovf   = (den_e == 64'd0) || (den_e > MAXPOS) || (num_reg > MAXPOS + {63'd0, neg_e});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    priority if (q_item.op == OP_ERR) state_next = S_OUT;
                    else if (q_item.op == OP_POW) state_next = S_GCD;
                    else state_next = S_MUL;
                end
            end
            S_MUL:   if (step_reg[1:0] == 2'd3) state_next = S_SUM;
            S_SUM:   state_next = S_GCD;
            S_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = (g_val == 64'd0) ? S_CHK : S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == 7'd63)
                begin
                    state_next = pow_pass_reg ? S_PSET : S_CHK;
                end
            end
            S_PSET:
            begin
                state_next = (it_reg.e_neg && num_reg == 64'd0) ? S_OUT : S_PINIT;
            end
            S_PINIT:
            begin
                state_next = (it_reg.e_mag == 32'd0 || base_reg <= 32'd1) ? S_PNEXT : S_PMUL;
            end
            S_PMUL:  state_next = S_PCHK;
            S_PCHK:
            begin
                priority if (prod_reg > POW_CAP) state_next = S_OUT;
                else if (cnt_reg == 32'd1) state_next = S_PNEXT;
                else state_next = S_PMUL;
            end
            S_PNEXT: state_next = which_reg ? S_GCD : S_PINIT;
            S_CHK:   state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(op_a) * 64'(op_b);
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    it_reg       <= q_item;
                    step_reg     <= 7'd0;
                    pow_pass_reg <= 1'b1;
                    num_reg      <= {32'd0, q_item.an};
                    den_reg      <= {32'd0, q_item.ad};
                    x_reg        <= {32'd0, q_item.an};
                    y_reg        <= {32'd0, q_item.ad};
                    k_reg        <= 6'd0;
                    res_num_reg  <= 32'd0;
                    res_den_reg  <= 31'd1;
                    status_reg   <= q_item.status;
                end
            end
            S_MUL:
            begin
                step_reg <= step_reg + 7'd1;
                unique case (step_reg[1:0])
                    2'd1:    t1_reg  <= prod_reg;
                    2'd2:    t2_reg  <= prod_reg;
                    2'd3:    den_reg <= prod_reg;
                    default: ;
                endcase
            end
            S_SUM:
            begin
                pow_pass_reg <= 1'b0;
                k_reg        <= 6'd0;
                y_reg        <= den_reg;
                if (it_reg.op == OP_ADD)
                begin
                    num_reg <= sum_m;
                    x_reg   <= sum_m;
                    neg_reg <= sum_neg;
                end
                else
                begin
                    num_reg <= t1_reg;
                    x_reg   <= t1_reg;
                    neg_reg <= it_reg.a_neg ^ it_reg.b_neg;
                end
            end
            S_GCD:
            begin
                // binary gcd, one step a cycle
                priority if (gcd_done)
                begin
                    g_reg     <= g_val;
                    rem_n_reg <= 64'd0;
                    rem_d_reg <= 64'd0;
                    step_reg  <= 7'd0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end
                else if (!x_reg[0]) x_reg <= x_reg >> 1;
                else if (!y_reg[0]) y_reg <= y_reg >> 1;
                else if (x_reg >= y_reg) x_reg <= x_reg - y_reg;
                else y_reg <= y_reg - x_reg;
            end
            S_DIV:
            begin
                // numerator and denominator divided by g, one quotient bit a cycle
                step_reg  <= step_reg + 7'd1;
                rem_n_reg <= rn_dif[64] ? rn_sh[63:0] : rn_dif[63:0];
                rem_d_reg <= rd_dif[64] ? rd_sh[63:0] : rd_dif[63:0];
                num_reg   <= {num_reg[62:0], ~rn_dif[64]};
                den_reg   <= {den_reg[62:0], ~rd_dif[64]};
            end
            S_PSET:
            begin
                base_reg  <= num_reg[31:0];
                which_reg <= 1'b0;
                if (it_reg.e_neg && num_reg == 64'd0)
                begin
                    status_reg <= ST_DIVZERO;
                end
            end
            S_PINIT:
            begin
                cnt_reg <= it_reg.e_mag;
                priority if (it_reg.e_mag == 32'd0) r_reg <= 32'd1;
                else if (base_reg <= 32'd1) r_reg <= base_reg;
                else r_reg <= 32'd1;
            end
            S_PMUL: ;
            S_PCHK:
            begin
                if (prod_reg > POW_CAP)
                begin
                    status_reg <= ST_OVERFLOW;
                end
                r_reg   <= prod_reg[31:0];
                cnt_reg <= cnt_reg - 32'd1;
            end
            S_PNEXT:
            begin
                if (!which_reg)
                begin
                    pp_reg    <= r_reg;
                    base_reg  <= den_reg[31:0];
                    which_reg <= 1'b1;
                end
                else
                begin
                    pow_pass_reg <= 1'b0;
                    k_reg        <= 6'd0;
                    neg_reg      <= it_reg.a_neg & it_reg.e_mag[0];
                    if (it_reg.e_neg)
                    begin
                        num_reg <= {32'd0, r_reg};
                        den_reg <= {32'd0, pp_reg};
                        x_reg   <= {32'd0, r_reg};
                        y_reg   <= {32'd0, pp_reg};
                    end
                    else
                    begin
                        num_reg <= {32'd0, pp_reg};
                        den_reg <= {32'd0, r_reg};
                        x_reg   <= {32'd0, pp_reg};
                        y_reg   <= {32'd0, r_reg};
                    end
                end
            end
            S_CHK:
            begin
                if (ovf)
                begin
                    status_reg  <= ST_OVERFLOW;
                    res_num_reg <= 32'd0;
                    res_den_reg <= 31'd1;
                end
                else
                begin
                    status_reg  <= ST_OK;
                    res_num_reg <= neg_e ? (32'd0 - num_reg[31:0]) : num_reg[31:0];
                    res_den_reg <= den_e[30:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg != ST_OK) |-> (res_num_reg == 32'd0 && res_den_reg == 31'd1))
        else $error("error result not 0/1");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ST_OK) |-> (res_den_reg != 31'd0))
        else $error("zero denominator delivered");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != S_IDLE))
        else $error("item taken but sequencer idle");

    a_div_by_g: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (g_reg != 64'd0))
        else $error("divider started with zero gcd");

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: front, item queue and back.
// Depends on rau_pkg, rau_front, rau_fifo and rau_back.
//
// Adds, subtracts, multiplies or divides two fractions, or raises the first to
// a signed integer power, and returns the result reduced to lowest terms with a
// positive denominator. One item is worked at a time by the back sequencer; the
// front takes up to two further beats into its queue meanwhile. An item passes
// the shared multiplier, the sum stage, the binary gcd, the divide of numerator
// and denominator by the gcd, one quotient bit per cycle, and the range check;
// with a zero numerator the gcd is done on entry. A power item has no multiplier
// stage but runs a gcd and divide of the base, multiply-and-check steps for the
// two powers, then a gcd and divide of the result. Invalid operands and division
// by a zero fraction go from the queue straight to the output without any of
// these steps; zero to a negative power is only seen once the base is reduced.
module rational_arithmetic_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96], exponent[159:128]
    input  logic [rau_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd[2:0]
    input  logic [rau_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // res_num[31:0], res_den[62:32], zero[63]
    output logic [rau_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [rau_pkg::OUT_USER_W-1:0]  m_tuser
);
    import rau_pkg::*;

    item_t       push_item, pop_item;
    logic        push, full, pop, q_valid;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;

    rau_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    rau_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    rau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

    // output beat packing
    assign m_tdata = {1'b0, res_den, res_num};
    assign m_tuser = status;

endmodule
